FILE: hdl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants of the glyph span rasterizer
// Command format between the front and back ends, the back-end state
// encoding, character code constants and the saturating coordinate add.
// ----------------------------------------------------------------------------
package gsr_pkg;

   // glyph geometry and coordinate range
   localparam int          GLYPH_SIZE = 8;
   localparam int          COORD_W    = 12;
   localparam int          ROW_W      = $clog2(GLYPH_SIZE);
   localparam int          COL_W      = ROW_W + 1;
   localparam int          GLYPH_W    = 7;
   localparam logic [11:0] COORD_MAX  = 12'd4095;

   // character codes
   localparam logic [7:0] CHAR_FIRST    = 8'd32;
   localparam logic [7:0] CHAR_LAST     = 8'd127;
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_FALLBACK = 8'd63;

   // action codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_DRAW = 1'b1;

   // command queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                 load;
      logic [9:0]           font_address;
      logic [7:0]           row_bits;
      logic [GLYPH_W-1:0]   glyph;
      logic [COORD_W-1:0]   text_x;
      logic [COORD_W-1:0]   text_y;
   } gsr_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH
   } gsr_state_type;

   // coordinate plus small offset, clamped at the top of the range
   function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                  input logic [COL_W-1:0]   b);
      logic [COORD_W:0] s;
      s = {1'b0, a} + {{(COORD_W + 1 - COL_W){1'b0}}, b};
      return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
   endfunction

endpackage

FILE: hdl/gsr_queue.sv
// ----------------------------------------------------------------------------
// gsr_queue: command queue
// Small register FIFO that decouples the classifying front end from the
// span generating back end.
// ----------------------------------------------------------------------------
module gsr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gsr_pkg::gsr_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output gsr_pkg::gsr_cmd_type head_cmd
);
   import gsr_pkg::*;

   gsr_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   // status and head
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update; pointers wrap naturally
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/gsr_front.sv
// ----------------------------------------------------------------------------
// gsr_front: item intake and classification
// Accepts load and draw items, keeps the text cursor, handles newlines
// locally and queues font writes and glyph draws for the back end.
// ----------------------------------------------------------------------------
module gsr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [9:0]           req_font_address,
   input  logic [7:0]           req_font_row_bits,
   input  logic [7:0]           req_character,
   input  logic [8:0]           req_origin_col,
   input  logic [8:0]           req_origin_row,
   input  logic                 req_first_of_string,
   input  logic                 q_full,
   output logic                 q_push,
   output gsr_pkg::gsr_cmd_type q_cmd
);
   import gsr_pkg::*;

   logic [COORD_W-1:0] text_x_ff, text_x_in;
   logic [COORD_W-1:0] text_y_ff, text_y_in;
   logic [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic [COORD_W-1:0] ox_first, oy_first;
   logic [COORD_W-1:0] ox_cur, cx_cur, cy_cur;
   logic               accept, draw, newline;
   logic [GLYPH_W-1:0] glyph;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign draw      = accept && (req_action == ACTION_DRAW);
   assign newline   = (req_character == CHAR_NEWLINE);

   // origin in pixels; a 9-bit cell index times eight never exceeds the range
   assign ox_first = {req_origin_col, 3'b000};
   assign oy_first = {req_origin_row, 3'b000};
   assign ox_cur   = req_first_of_string ? ox_first : origin_x_ff;
   assign cx_cur   = req_first_of_string ? ox_first : text_x_ff;
   assign cy_cur   = req_first_of_string ? oy_first : text_y_ff;

   // printable range check, everything else draws as the fallback glyph
   assign glyph = ((req_character < CHAR_FIRST) || (req_character > CHAR_LAST)) ?
                  CHAR_FALLBACK[GLYPH_W-1:0] : req_character[GLYPH_W-1:0];

   // cursor update
   always_comb begin
      origin_x_in = origin_x_ff;
      text_x_in   = text_x_ff;
      text_y_in   = text_y_ff;
      if (draw) begin
         origin_x_in = ox_cur;
         if (newline) begin
            text_x_in = ox_cur;
            text_y_in = sat_add(cy_cur, COL_W'(GLYPH_SIZE));
         end else begin
            text_x_in = sat_add(cx_cur, COL_W'(GLYPH_SIZE));
            text_y_in = cy_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         text_x_ff   <= '0;
         text_y_ff   <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         text_x_ff   <= text_x_in;
         text_y_ff   <= text_y_in;
      end
   end

   // queue push: every load, and draws other than newline
   always_comb begin
      q_push             = accept && ((req_action == ACTION_LOAD) || !newline);
      q_cmd.load         = (req_action == ACTION_LOAD);
      q_cmd.font_address = req_font_address;
      q_cmd.row_bits     = req_font_row_bits;
      q_cmd.glyph        = glyph;
      q_cmd.text_x       = cx_cur;
      q_cmd.text_y       = cy_cur;
   end

endmodule

FILE: hdl/gsr_back.sv
// ----------------------------------------------------------------------------
// gsr_back: font memory and span generator
// Executes queued font writes and walks the eight rows of a glyph, one
// memory read per row, emitting one span per run of set pixels.
// ----------------------------------------------------------------------------
module gsr_back #(
   parameter int FONT_ENTRIES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  gsr_pkg::gsr_cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [11:0]          rsp_span_left,
   output logic [11:0]          rsp_span_top,
   output logic [11:0]          rsp_span_right,
   output logic [11:0]          rsp_span_bottom,
   output logic                 rsp_last_of_char
);
   import gsr_pkg::*;

   localparam int AW = $clog2(FONT_ENTRIES);

   logic [7:0]          font_mem [FONT_ENTRIES];
   logic [7:0]          rd_data_ff;
   logic                rd_en, mem_we;
   logic [AW-1:0]       rd_addr, wr_addr;

   gsr_state_type       state_ff, state_in;
   logic [GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [ROW_W-1:0]    row_ff, row_in, row_sel;
   logic [COL_W-1:0]    col_ff, col_in;

   logic                pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0]  pend_left_ff, pend_top_ff, pend_right_ff, pend_bottom_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  out_left_ff, out_top_ff, out_right_ff, out_bottom_ff;
   logic                out_last_ff;

   logic [7:0]          remaining, after_run;
   logic [COL_W-1:0]    run_begin, run_end;
   logic                start_found, end_found;
   logic                span_found, row_done, out_free, scan_go;
   logic                pend_load, out_load, out_last;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // run finder over the current row: first set pixel at or after col_ff,
   // then the first clear pixel after it
   always_comb begin
      remaining   = rd_data_ff & (8'hFF >> col_ff);
      run_begin   = '0;
      run_end     = COL_W'(GLYPH_SIZE);
      start_found = 1'b0;
      end_found   = 1'b0;
      for (int c = 0; c < GLYPH_SIZE; c++) begin
         if (!start_found && remaining[GLYPH_SIZE-1-c]) begin
            run_begin   = COL_W'(c);
            start_found = 1'b1;
         end
      end
      for (int c = 0; c < GLYPH_SIZE; c++) begin
         if (!end_found && (COL_W'(c) > run_begin) && !rd_data_ff[GLYPH_SIZE-1-c]) begin
            run_end   = COL_W'(c);
            end_found = 1'b1;
         end
      end
      after_run  = rd_data_ff & (8'hFF >> run_end);
      span_found = (remaining != '0);
      row_done   = !span_found || (after_run == '0);
   end

   // a found span needs the pending slot free, or the output able to take it
   assign scan_go = (state_ff == ST_SCAN) && (!span_found || !pend_valid_ff || out_free);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !q_cmd.load) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_go && row_done && (row_ff == ROW_W'(GLYPH_SIZE - 1))) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      row_sel   = row_ff;
      pend_load = 1'b0;
      out_load  = 1'b0;
      out_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop  = q_valid;
            mem_we = q_valid && q_cmd.load;
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         ST_SCAN: begin
            pend_load = scan_go && span_found;
            out_load  = scan_go && span_found && pend_valid_ff;
            rd_en     = scan_go && row_done && (row_ff != ROW_W'(GLYPH_SIZE - 1));
            row_sel   = row_ff + 1'b1;
         end
         ST_FINISH: begin
            out_load = pend_valid_ff && out_free;
            out_last = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   assign rd_addr = AW'({glyph_ff, row_sel});
   assign wr_addr = AW'(q_cmd.font_address);

   // font memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[wr_addr] <= q_cmd.row_bits;
      end
      if (rd_en) begin
         rd_data_ff <= font_mem[rd_addr];
      end
   end

   // glyph walk registers
   always_comb begin
      glyph_in = glyph_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if ((state_ff == ST_IDLE) && q_valid && !q_cmd.load) begin
         glyph_in = q_cmd.glyph;
         cx_in    = q_cmd.text_x;
         cy_in    = q_cmd.text_y;
         row_in   = '0;
         col_in   = '0;
      end else if (scan_go) begin
         if (row_done) begin
            row_in = row_ff + 1'b1;
            col_in = '0;
         end else begin
            col_in = run_end;
         end
      end
   end

   // pending span and output register flags
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (pend_load) begin
         pend_valid_in = 1'b1;
      end else if (out_load) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      if (pend_load) begin
         pend_left_ff   <= sat_add(cx_ff, run_begin);
         pend_top_ff    <= sat_add(cy_ff, {1'b0, row_ff});
         pend_right_ff  <= sat_add(cx_ff, run_end);
         pend_bottom_ff <= sat_add(cy_ff, {1'b0, row_ff} + 1'b1);
      end
      if (out_load) begin
         out_left_ff   <= pend_left_ff;
         out_top_ff    <= pend_top_ff;
         out_right_ff  <= pend_right_ff;
         out_bottom_ff <= pend_bottom_ff;
         out_last_ff   <= out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_left    = out_left_ff;
   assign rsp_span_top     = out_top_ff;
   assign rsp_span_right   = out_right_ff;
   assign rsp_span_bottom  = out_bottom_ff;
   assign rsp_last_of_char = out_last_ff;

   // no span is left behind when a glyph is finished
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending span left over in idle");

   // a result is never overwritten before it is taken
   a_out_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten");

   // first row read leads into scanning of row zero
   a_fetch_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> ((state_ff == ST_SCAN) && (row_ff == '0)))
      else $error("fetch did not start scanning at row zero");

endmodule

FILE: hdl/glyph_span_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_span_rasterizer: 8x8 bitmap font text to pixel spans
// Top level joining the intake front end, command queue and span back end.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while the four-entry command queue
// has room; newline items are absorbed there and use no back-end time. In the
// back end a font load is written to the font memory as it leaves the queue.
// A draw leaves the queue, starts the first font read in the fetch state, then
// scans each glyph row in turn, emitting one span per run of set pixels (a row
// without set pixels still takes a scan step), and ends in a closing state.
// The font memory is read one row at a time, and the run finder yields one
// span per cycle unless the output path is held. Each span leaves through a
// pending slot and an output register, so the back end keeps scanning while
// one result waits; it stalls only when both are held.
module glyph_span_rasterizer #(
   parameter int FONT_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [9:0]  req_font_address,
   input  logic [7:0]  req_font_row_bits,
   input  logic [7:0]  req_character,
   input  logic [8:0]  req_origin_col,
   input  logic [8:0]  req_origin_row,
   input  logic        req_first_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_span_left,
   output logic [11:0] rsp_span_top,
   output logic [11:0] rsp_span_right,
   output logic [11:0] rsp_span_bottom,
   output logic        rsp_last_of_char
);
   import gsr_pkg::*;

   logic        q_push, q_full, q_pop, q_valid;
   gsr_cmd_type push_cmd, head_cmd;

   gsr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_font_address    (req_font_address),
      .req_font_row_bits   (req_font_row_bits),
      .req_character       (req_character),
      .req_origin_col      (req_origin_col),
      .req_origin_row      (req_origin_row),
      .req_first_of_string (req_first_of_string),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (push_cmd)
   );

   gsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   gsr_back #(
      .FONT_ENTRIES (FONT_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_span_left    (rsp_span_left),
      .rsp_span_top     (rsp_span_top),
      .rsp_span_right   (rsp_span_right),
      .rsp_span_bottom  (rsp_span_bottom),
      .rsp_last_of_char (rsp_last_of_char)
   );

endmodule
